// ----- hw/rtl/cmfs_pkg.sv -----
// ----------------------------------------------------------------------------
// cmfs_pkg: shared types and constants for the cube map face select pipeline
// Component and coordinate widths, face codes, stage layout, divider step.
// ----------------------------------------------------------------------------
`default_nettype none

package cmfs_pkg;

    localparam int COMP_W  = 16;  // direction component width, signed
    localparam int COORD_W = 16;  // face coordinate fraction bits
    localparam int FACE_W  = 3;

    localparam logic [FACE_W-1:0] FACE_POS_X = 3'd0;
    localparam logic [FACE_W-1:0] FACE_NEG_X = 3'd1;
    localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd2;
    localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd3;
    localparam logic [FACE_W-1:0] FACE_POS_Z = 3'd4;
    localparam logic [FACE_W-1:0] FACE_NEG_Z = 3'd5;

    localparam logic [COORD_W-1:0] COORD_HALF = {1'b1, {(COORD_W-1){1'b0}}};

    // stage layout: input, select, divider init plus one stage per quotient bit, output
    localparam int DIV_FIRST  = 2;
    localparam int OUT_STAGE  = DIV_FIRST + COORD_W + 1;
    localparam int NUM_STAGES = OUT_STAGE + 1;

    typedef struct packed {
        logic signed [COMP_W-1:0] x;
        logic signed [COMP_W-1:0] y;
        logic signed [COMP_W-1:0] z;
        logic        [COMP_W-1:0] ax;
        logic        [COMP_W-1:0] ay;
        logic        [COMP_W-1:0] az;
    } in_stage_t;

    typedef struct packed {
        logic [FACE_W-1:0]      face;
        logic                   zero;
        logic [COMP_W-1:0]      mag;
        logic signed [COMP_W:0] sc;
        logic signed [COMP_W:0] tc;
    } sel_stage_t;

    typedef struct packed {
        logic [FACE_W-1:0]  face;
        logic               zero;
        logic [COMP_W:0]    den;
        logic [COMP_W:0]    rem_u;
        logic [COMP_W:0]    rem_v;
        logic [COORD_W-1:0] q_u;
        logic [COORD_W-1:0] q_v;
    } div_stage_t;

    typedef struct packed {
        logic            qbit;
        logic [COMP_W:0] rem;
    } step_t;

    // one restoring division step, remainder never exceeds the divisor
    function automatic step_t div_step(input logic [COMP_W:0] rem,
                                       input logic [COMP_W:0] den);
        logic [COMP_W+1:0] sh;
        logic [COMP_W+1:0] diff;
        step_t             r;
        sh   = {rem, 1'b0};
        diff = sh - {1'b0, den};
        if (sh >= {1'b0, den}) begin
            r.qbit = 1'b1;
            r.rem  = diff[COMP_W:0];
        end else begin
            r.qbit = 1'b0;
            r.rem  = sh[COMP_W:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/cube_map_face_select.sv -----
// ----------------------------------------------------------------------------
// cube_map_face_select: direction vector to cube face and face coordinates
// Picks the major axis, negates the minor axes per face and divides them into
// unsigned fractions with a bit-per-stage restoring divider.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake          payload
//  s_       in   s_valid/s_ready    s_dir_x, s_dir_y, s_dir_z
//  m_       out  m_valid/m_ready    m_face, m_coord_u, m_coord_v, m_zero_dir
//
//  one transaction per cycle while the output is not stalled by m_ready low;
//  the divider takes one quotient bit per stage for both coordinates
//  each stage holds its data when the next one is full and stalled, so empty
//  stages are filled while the output waits
//  reset (aresetn low at a clock edge) clears only the stage valid bits
// ----------------------------------------------------------------------------
`default_nettype none

module cube_map_face_select (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    input  wire                                   s_valid,
    output logic                                  s_ready,
    input  wire  signed [cmfs_pkg::COMP_W-1:0]    s_dir_x,
    input  wire  signed [cmfs_pkg::COMP_W-1:0]    s_dir_y,
    input  wire  signed [cmfs_pkg::COMP_W-1:0]    s_dir_z,
    output logic                                  m_valid,
    input  wire                                   m_ready,
    output logic        [cmfs_pkg::FACE_W-1:0]    m_face,
    output logic        [cmfs_pkg::COORD_W-1:0]   m_coord_u,
    output logic        [cmfs_pkg::COORD_W-1:0]   m_coord_v,
    output logic                                  m_zero_dir
);

    localparam int CW = cmfs_pkg::COMP_W;
    localparam int QW = cmfs_pkg::COORD_W;
    localparam int NS = cmfs_pkg::NUM_STAGES;

    logic [NS-1:0] v_reg;
    logic [NS-1:0] v_next;
    logic [NS-1:0] en;

    cmfs_pkg::in_stage_t  in_reg,  in_next;
    cmfs_pkg::sel_stage_t sel_reg, sel_next;
    cmfs_pkg::div_stage_t div_reg [0:QW];
    cmfs_pkg::div_stage_t div_next [0:QW];

    logic [cmfs_pkg::FACE_W-1:0] face_reg;
    logic [QW-1:0]               u_reg;
    logic [QW-1:0]               v_out_reg;
    logic                        zero_reg;

    // a stage loads when it is empty or its content moves on
    always_comb begin
        en[NS-1] = !v_reg[NS-1] || m_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !v_reg[k] || en[k+1];
        end
        v_next[0] = en[0] ? s_valid : v_reg[0];
        for (int k = 1; k < NS; k++) begin
            v_next[k] = en[k] ? v_reg[k-1] : v_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    // stage 0: capture and take magnitudes
    always_comb begin
        in_next.x  = s_dir_x;
        in_next.y  = s_dir_y;
        in_next.z  = s_dir_z;
        in_next.ax = s_dir_x[CW-1] ? (~s_dir_x + {{(CW-1){1'b0}}, 1'b1}) : s_dir_x;
        in_next.ay = s_dir_y[CW-1] ? (~s_dir_y + {{(CW-1){1'b0}}, 1'b1}) : s_dir_y;
        in_next.az = s_dir_z[CW-1] ? (~s_dir_z + {{(CW-1){1'b0}}, 1'b1}) : s_dir_z;
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            in_reg <= in_next;
        end
    end

    // stage 1: major axis and signed minor components
    logic signed [CW:0] xe, ye, ze;
    logic               ge_x, ge_y;

    always_comb begin
        xe   = {in_reg.x[CW-1], in_reg.x};
        ye   = {in_reg.y[CW-1], in_reg.y};
        ze   = {in_reg.z[CW-1], in_reg.z};
        ge_x = (in_reg.ax >= in_reg.ay) && (in_reg.ax >= in_reg.az);
        ge_y = (in_reg.ay >= in_reg.ax) && (in_reg.ay >= in_reg.az);
        sel_next.zero = (in_reg.ax == '0) && (in_reg.ay == '0) && (in_reg.az == '0);
        if (ge_x) begin
            sel_next.mag = in_reg.ax;
            sel_next.tc  = -ye;
            if (!in_reg.x[CW-1] && (in_reg.x != '0)) begin
                sel_next.face = cmfs_pkg::FACE_POS_X;
                sel_next.sc   = -ze;
            end else begin
                // zero component counts as negative
                sel_next.face = cmfs_pkg::FACE_NEG_X;
                sel_next.sc   = ze;
            end
        end else if (ge_y) begin
            sel_next.mag = in_reg.ay;
            sel_next.sc  = xe;
            if (!in_reg.y[CW-1] && (in_reg.y != '0)) begin
                sel_next.face = cmfs_pkg::FACE_POS_Y;
                sel_next.tc   = ze;
            end else begin
                sel_next.face = cmfs_pkg::FACE_NEG_Y;
                sel_next.tc   = -ze;
            end
        end else begin
            sel_next.mag = in_reg.az;
            sel_next.tc  = -ye;
            if (!in_reg.z[CW-1] && (in_reg.z != '0)) begin
                sel_next.face = cmfs_pkg::FACE_POS_Z;
                sel_next.sc   = xe;
            end else begin
                sel_next.face = cmfs_pkg::FACE_NEG_Z;
                sel_next.sc   = -xe;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            sel_reg <= sel_next;
        end
    end

    // stage 2: numerators c + m and divisor 2m
    logic signed [CW+1:0] sum_u, sum_v;

    always_comb begin
        sum_u = {sel_reg.sc[CW], sel_reg.sc} + {2'b00, sel_reg.mag};
        sum_v = {sel_reg.tc[CW], sel_reg.tc} + {2'b00, sel_reg.mag};
        div_next[0].face  = sel_reg.face;
        div_next[0].zero  = sel_reg.zero;
        div_next[0].den   = {sel_reg.mag, 1'b0};
        div_next[0].rem_u = sum_u[CW:0];
        div_next[0].rem_v = sum_v[CW:0];
        div_next[0].q_u   = '0;
        div_next[0].q_v   = '0;
    end

    always_ff @(posedge aclk) begin
        if (en[cmfs_pkg::DIV_FIRST]) begin
            div_reg[0] <= div_next[0];
        end
    end

    // one quotient bit per stage; numerator equal to divisor yields all ones,
    // which is the saturated value
    genvar gi;
    generate
        for (gi = 1; gi <= QW; gi++) begin : g_div
            cmfs_pkg::step_t su, sv;

            always_comb begin
                su = cmfs_pkg::div_step(div_reg[gi-1].rem_u, div_reg[gi-1].den);
                sv = cmfs_pkg::div_step(div_reg[gi-1].rem_v, div_reg[gi-1].den);
                div_next[gi].face  = div_reg[gi-1].face;
                div_next[gi].zero  = div_reg[gi-1].zero;
                div_next[gi].den   = div_reg[gi-1].den;
                div_next[gi].rem_u = su.rem;
                div_next[gi].rem_v = sv.rem;
                div_next[gi].q_u   = {div_reg[gi-1].q_u[QW-2:0], su.qbit};
                div_next[gi].q_v   = {div_reg[gi-1].q_v[QW-2:0], sv.qbit};
            end

            always_ff @(posedge aclk) begin
                if (en[cmfs_pkg::DIV_FIRST + gi]) begin
                    div_reg[gi] <= div_next[gi];
                end
            end
        end
    endgenerate

    // output stage: zero vector overrides the quotients
    always_ff @(posedge aclk) begin
        if (en[cmfs_pkg::OUT_STAGE]) begin
            face_reg  <= div_reg[QW].face;
            zero_reg  <= div_reg[QW].zero;
            u_reg     <= div_reg[QW].zero ? cmfs_pkg::COORD_HALF : div_reg[QW].q_u;
            v_out_reg <= div_reg[QW].zero ? cmfs_pkg::COORD_HALF : div_reg[QW].q_v;
        end
    end

    assign s_ready    = en[0];
    assign m_valid    = v_reg[NS-1];
    assign m_face     = face_reg;
    assign m_coord_u  = u_reg;
    assign m_coord_v  = v_out_reg;
    assign m_zero_dir = zero_reg;

    a_zero_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_zero_dir) |-> (m_face == cmfs_pkg::FACE_NEG_X)
            && (m_coord_u == cmfs_pkg::COORD_HALF) && (m_coord_v == cmfs_pkg::COORD_HALF))
        else $error("zero direction result is not face -x at one half");

    a_face_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_face <= cmfs_pkg::FACE_NEG_Z))
        else $error("face index out of range");

    a_full_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> ((&v_reg) && !m_ready))
        else $error("input blocked while the pipeline has an empty stage");

    a_output_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (v_reg[NS-2] && (!m_valid || m_ready)) |=> m_valid)
        else $error("transaction lost at the output stage");

endmodule

`default_nettype wire
